// ----- hw/rtl/timed_rgbw_light_interpolator_top_defines.svh -----
// ----------------------------------------------------------------------------
// timed rgbw light interpolator assertion macros
// shared concurrent assertion forms, clocked on clk_i and muted in reset
// ----------------------------------------------------------------------------
`ifndef TIMED_RGBW_LIGHT_INTERPOLATOR_TOP_DEFINES_SVH
`define TIMED_RGBW_LIGHT_INTERPOLATOR_TOP_DEFINES_SVH

// same-cycle implication
`define TRLI_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("trli assertion failed");

// next-cycle implication
`define TRLI_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("trli assertion failed");

`endif

// ----- hw/rtl/trli_pkg.sv -----
// ----------------------------------------------------------------------------
// trli_pkg
// types and constants shared by the light interpolator controller and datapath
// ----------------------------------------------------------------------------
package trli_pkg;

  localparam int unsigned HOUR_W    = 5;
  localparam int unsigned MIN_W     = 6;
  localparam int unsigned LVL_W     = 8;
  localparam int unsigned NCH       = 4;
  localparam int unsigned HOURS_DAY = 24;
  localparam int unsigned NOON_HOUR = 12;
  localparam int unsigned LVL_MAX   = 255;
  localparam int unsigned MIN_PER_H = 60;
  localparam int unsigned SEC_PER_M = 60;
  localparam int unsigned QUO_W     = 9;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
  } hm_t;

  typedef struct packed {
    hm_t                       hm;
    logic [NCH-1:0][LVL_W-1:0] lvl;
  } entry_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_SCAN_END,
    ST_WALK_RD,
    ST_WALK_EV,
    ST_TP_BOTH,
    ST_ADV_CHK,
    ST_ADV_RD,
    ST_ADV_EV,
    ST_TP_NEXT,
    ST_PLV_RD,
    ST_PLV_EV,
    ST_NLV_RD,
    ST_NLV_EV,
    ST_ND,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_STORE,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    A_HOLD,
    A_ZERO,
    A_INC,
    A_NEXT_INC,
    A_PREV,
    A_NEXT
  } addr_sel_e;

  typedef struct packed {
    addr_sel_e addr_sel;
    logic      write_entry;
    logic      capture_now;
    logic      start_scan;
    logic      set_no_entries;
    logic      set_prev;
    logic      set_first;
    logic      set_next;
    logic      next_from_first;
    logic      prev_from_next;
    logic      tp_both;
    logic      adv;
    logic      tp_next;
    logic      load_plev;
    logic      load_nlev;
    logic      calc_nd;
    logic      ch_clr;
    logic      ch_inc;
    logic      mul;
    logic      sum;
    logic      div_step;
    logic      store;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic rescan_pending;
    logic no_entries;
    logic rd_valid;
    logic rd_later;
    logic rd_same_next;
    logic rd_last;
    logic adv_needed;
    logic div_done;
    logic ch_last;
    logic out_free;
  } status_t;

endpackage

// ----- hw/rtl/trli_ctrl.sv -----
// ----------------------------------------------------------------------------
// trli_ctrl
// sequencer: schedule scan, predecessor walk, advance and per-channel blend
// ----------------------------------------------------------------------------
`include "timed_rgbw_light_interpolator_top_defines.svh"

module trli_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_op_i,
  output logic              in_ready_o,
  input  trli_pkg::status_t status_i,
  output trli_pkg::cmd_t    cmd_o
);

  trli_pkg::state_e state_q, state_d;
  logic             have_prev_q, have_prev_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= trli_pkg::ST_IDLE;
      have_prev_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      have_prev_q <= have_prev_d;
    end
  end

  assign in_ready_o = (state_q == trli_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      trli_pkg::ST_IDLE: begin
        if (in_valid_i && (in_op_i == trli_pkg::OP_TICK)) begin
          priority if (status_i.rescan_pending) state_d = trli_pkg::ST_SCAN_RD;
          else if (status_i.no_entries)         state_d = trli_pkg::ST_DONE;
          else                                  state_d = trli_pkg::ST_ADV_CHK;
        end
      end
      trli_pkg::ST_SCAN_RD: state_d = trli_pkg::ST_SCAN_EV;
      trli_pkg::ST_SCAN_EV: begin
        priority if (status_i.rd_valid && status_i.rd_later) begin
          state_d = have_prev_q ? trli_pkg::ST_TP_BOTH : trli_pkg::ST_WALK_RD;
        end else if (status_i.rd_last) begin
          state_d = trli_pkg::ST_SCAN_END;
        end else begin
          state_d = trli_pkg::ST_SCAN_RD;
        end
      end
      trli_pkg::ST_SCAN_END: begin
        state_d = have_prev_q ? trli_pkg::ST_TP_BOTH : trli_pkg::ST_DONE;
      end
      trli_pkg::ST_WALK_RD: state_d = trli_pkg::ST_WALK_EV;
      trli_pkg::ST_WALK_EV: begin
        if (status_i.rd_valid && status_i.rd_same_next) state_d = trli_pkg::ST_TP_BOTH;
        else                                            state_d = trli_pkg::ST_WALK_RD;
      end
      trli_pkg::ST_TP_BOTH: state_d = trli_pkg::ST_ADV_CHK;
      trli_pkg::ST_ADV_CHK: begin
        state_d = status_i.adv_needed ? trli_pkg::ST_ADV_RD : trli_pkg::ST_PLV_RD;
      end
      trli_pkg::ST_ADV_RD: state_d = trli_pkg::ST_ADV_EV;
      trli_pkg::ST_ADV_EV: begin
        state_d = status_i.rd_valid ? trli_pkg::ST_TP_NEXT : trli_pkg::ST_ADV_RD;
      end
      trli_pkg::ST_TP_NEXT: state_d = trli_pkg::ST_PLV_RD;
      trli_pkg::ST_PLV_RD:  state_d = trli_pkg::ST_PLV_EV;
      trli_pkg::ST_PLV_EV:  state_d = trli_pkg::ST_NLV_RD;
      trli_pkg::ST_NLV_RD:  state_d = trli_pkg::ST_NLV_EV;
      trli_pkg::ST_NLV_EV:  state_d = trli_pkg::ST_ND;
      trli_pkg::ST_ND:      state_d = trli_pkg::ST_MUL;
      trli_pkg::ST_MUL:     state_d = trli_pkg::ST_SUM;
      trli_pkg::ST_SUM:     state_d = trli_pkg::ST_DIV;
      trli_pkg::ST_DIV: begin
        if (status_i.div_done) state_d = trli_pkg::ST_STORE;
      end
      trli_pkg::ST_STORE: begin
        state_d = status_i.ch_last ? trli_pkg::ST_DONE : trli_pkg::ST_MUL;
      end
      trli_pkg::ST_DONE: begin
        if (status_i.out_free) state_d = trli_pkg::ST_IDLE;
      end
      default: state_d = trli_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o       = '0;
    cmd_o.addr_sel = trli_pkg::A_HOLD;
    have_prev_d = have_prev_q;
    unique case (state_q)
      trli_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == trli_pkg::OP_LOAD) begin
            cmd_o.write_entry = 1'b1;
          end else begin
            cmd_o.capture_now = 1'b1;
            if (status_i.rescan_pending) begin
              cmd_o.start_scan = 1'b1;
              cmd_o.addr_sel   = trli_pkg::A_ZERO;
              have_prev_d      = 1'b0;
            end
          end
        end
      end
      trli_pkg::ST_SCAN_EV: begin
        if (status_i.rd_valid && status_i.rd_later) begin
          cmd_o.set_next = 1'b1;
          // address still holds the slot just taken as next
          if (!have_prev_q) cmd_o.addr_sel = trli_pkg::A_INC;
        end else begin
          if (status_i.rd_valid) begin
            cmd_o.set_prev  = 1'b1;
            cmd_o.set_first = !have_prev_q;
            have_prev_d     = 1'b1;
          end
          if (!status_i.rd_last) cmd_o.addr_sel = trli_pkg::A_INC;
        end
      end
      trli_pkg::ST_SCAN_END: begin
        if (have_prev_q) cmd_o.next_from_first = 1'b1;
        else             cmd_o.set_no_entries  = 1'b1;
      end
      trli_pkg::ST_WALK_EV: begin
        if (status_i.rd_valid && status_i.rd_same_next) begin
          cmd_o.prev_from_next = !have_prev_q;
        end else begin
          if (status_i.rd_valid) begin
            cmd_o.set_prev = 1'b1;
            have_prev_d    = 1'b1;
          end
          cmd_o.addr_sel = trli_pkg::A_INC;
        end
      end
      trli_pkg::ST_TP_BOTH: cmd_o.tp_both = 1'b1;
      trli_pkg::ST_ADV_CHK: begin
        if (status_i.adv_needed) begin
          cmd_o.adv      = 1'b1;
          cmd_o.addr_sel = trli_pkg::A_NEXT_INC;
        end else begin
          cmd_o.addr_sel = trli_pkg::A_PREV;
        end
      end
      trli_pkg::ST_ADV_EV: begin
        if (status_i.rd_valid) cmd_o.set_next = 1'b1;
        else                   cmd_o.addr_sel = trli_pkg::A_INC;
      end
      trli_pkg::ST_TP_NEXT: begin
        cmd_o.tp_next  = 1'b1;
        cmd_o.addr_sel = trli_pkg::A_PREV;
      end
      trli_pkg::ST_PLV_EV: begin
        cmd_o.load_plev = 1'b1;
        cmd_o.addr_sel  = trli_pkg::A_NEXT;
      end
      trli_pkg::ST_NLV_EV: cmd_o.load_nlev = 1'b1;
      trli_pkg::ST_ND: begin
        cmd_o.calc_nd = 1'b1;
        cmd_o.ch_clr  = 1'b1;
      end
      trli_pkg::ST_MUL:  cmd_o.mul = 1'b1;
      trli_pkg::ST_SUM:  cmd_o.sum = 1'b1;
      trli_pkg::ST_DIV:  cmd_o.div_step = 1'b1;
      trli_pkg::ST_STORE: begin
        cmd_o.store  = 1'b1;
        cmd_o.ch_inc = !status_i.ch_last;
      end
      trli_pkg::ST_DONE: cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

  `TRLI_ASSERT_NEXT(a_tick_leaves_idle, in_valid_i && in_ready_o && (in_op_i == trli_pkg::OP_TICK), state_q != trli_pkg::ST_IDLE)
  `TRLI_ASSERT_NEXT(a_load_stays_idle, in_valid_i && in_ready_o && (in_op_i == trli_pkg::OP_LOAD), state_q == trli_pkg::ST_IDLE)
  `TRLI_ASSERT_IMP(a_out_load_free, cmd_o.out_load, status_i.out_free)

endmodule

// ----- hw/rtl/trli_datapath.sv -----
// ----------------------------------------------------------------------------
// trli_datapath
// schedule memory, slot and timepoint registers, multiply and serial divide
// ----------------------------------------------------------------------------
module trli_datapath #(
  parameter int unsigned SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  trli_pkg::cmd_t    cmd_i,
  output trli_pkg::status_t status_o,
  input  logic [3:0]        entry_index_i,
  input  logic              entry_valid_i,
  input  logic [4:0]        entry_hour_i,
  input  logic [5:0]        entry_minute_i,
  input  logic [7:0]        entry_red_i,
  input  logic [7:0]        entry_green_i,
  input  logic [7:0]        entry_blue_i,
  input  logic [7:0]        entry_white_i,
  input  logic [31:0]       now_unix_i,
  input  logic [4:0]        now_hour_i,
  input  logic [5:0]        now_minute_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              active_o,
  output logic [7:0]        level_red_o,
  output logic [7:0]        level_green_o,
  output logic [7:0]        level_blue_o,
  output logic [7:0]        level_white_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LW = trli_pkg::LVL_W;
  localparam int unsigned NC = trli_pkg::NCH;

  function automatic logic [IW-1:0] slot_inc(input logic [IW-1:0] a);
    return (a == IW'(SLOTS - 1)) ? '0 : a + 1'b1;
  endfunction

  // seconds from now to an entry, wrapped forward or backward by a day
  function automatic logic [31:0] tp_offset(input trli_pkg::hm_t e, input trli_pkg::hm_t n,
                                            input logic after);
    logic signed [7:0]  dh;
    logic signed [7:0]  dm;
    logic signed [31:0] t;
    dh = signed'(8'(e.hour)) - signed'(8'(n.hour));
    dm = signed'(8'(e.minute)) - signed'(8'(n.minute));
    if (after) begin
      if (dh < 0 || (dh == 0 && dm < 0)) dh = dh + 8'(trli_pkg::HOURS_DAY);
    end else begin
      if (dh > 0 || (dh == 0 && dm > 0)) dh = dh - 8'(trli_pkg::HOURS_DAY);
    end
    t = (32'(dh) * 32'sd60 + 32'(dm)) * 32'sd60;
    return unsigned'(t);
  endfunction

  trli_pkg::entry_t mem_q [SLOTS];
  trli_pkg::entry_t rd_mem_q, rd_ent, wr_ent;
  logic [SLOTS-1:0] valid_q, written_q;
  logic [IW-1:0]    addr_q, addr_d, rd_slot_q, wr_addr;
  logic             rd_wr_q, rd_valid_q, wr_en;

  logic [31:0]      now_unix_q;
  trli_pkg::hm_t    now_hm_q, prev_hm_q, next_hm_q, first_hm_q;
  logic [IW-1:0]    prev_slot_q, next_slot_q, first_slot_q;
  logic [31:0]      prev_tp_q, next_tp_q;
  logic             pending_q, no_entries_q;

  logic [NC-1:0][LW-1:0] plev_q, nlev_q, res_q, out_lvl_q;
  logic [31:0]      num_q, den_q, nd_den, nd_num;
  logic [1:0]       ch_q;
  logic [39:0]      m1_q, m2_q;
  logic [41:0]      rem_q, dsh_q;
  logic [trli_pkg::QUO_W-1:0] quo_q;
  logic [3:0]       cnt_q;
  logic             out_valid_q, out_active_q;

  assign wr_addr = IW'((IW + 4)'(entry_index_i));
  assign wr_en   = cmd_i.write_entry && ((IW + 4)'(entry_index_i) < (IW + 4)'(SLOTS));

  always_comb begin
    wr_ent.hm.hour   = entry_hour_i;
    wr_ent.hm.minute = entry_minute_i;
    wr_ent.lvl       = {entry_white_i, entry_blue_i, entry_green_i, entry_red_i};
  end

  // slots never written read as their power-up entry
  always_comb begin
    rd_ent = '0;
    if (rd_wr_q) begin
      rd_ent = rd_mem_q;
    end else if (rd_slot_q == IW'(1)) begin
      rd_ent.hm.hour = trli_pkg::HOUR_W'(trli_pkg::NOON_HOUR);
      rd_ent.lvl     = {NC{LW'(trli_pkg::LVL_MAX)}};
    end
  end

  always_comb begin
    unique case (cmd_i.addr_sel)
      trli_pkg::A_HOLD:     addr_d = addr_q;
      trli_pkg::A_ZERO:     addr_d = '0;
      trli_pkg::A_INC:      addr_d = slot_inc(addr_q);
      trli_pkg::A_NEXT_INC: addr_d = slot_inc(next_slot_q);
      trli_pkg::A_PREV:     addr_d = prev_slot_q;
      trli_pkg::A_NEXT:     addr_d = next_slot_q;
      default:              addr_d = addr_q;
    endcase
  end

  assign nd_den = next_tp_q - prev_tp_q;
  assign nd_num = now_unix_q - prev_tp_q;

  // schedule memory
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_ent;
    rd_mem_q  <= mem_q[addr_q];
    rd_slot_q <= addr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= SLOTS'(2'b11);
      written_q    <= '0;
      addr_q       <= '0;
      rd_wr_q      <= 1'b0;
      rd_valid_q   <= 1'b0;
      prev_slot_q  <= '0;
      next_slot_q  <= '0;
      first_slot_q <= '0;
      prev_tp_q    <= '0;
      next_tp_q    <= '0;
      pending_q    <= 1'b1;
      no_entries_q <= 1'b0;
      ch_q         <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      addr_q     <= addr_d;
      rd_wr_q    <= written_q[addr_q];
      rd_valid_q <= valid_q[addr_q];
      if (wr_en) begin
        valid_q[wr_addr]   <= entry_valid_i;
        written_q[wr_addr] <= 1'b1;
        pending_q          <= 1'b1;
      end
      if (cmd_i.start_scan)     pending_q    <= 1'b0;
      if (cmd_i.set_no_entries) no_entries_q <= 1'b1;
      if (cmd_i.tp_both)        no_entries_q <= 1'b0;
      if (cmd_i.set_prev)       prev_slot_q  <= rd_slot_q;
      if (cmd_i.set_first)      first_slot_q <= rd_slot_q;
      if (cmd_i.set_next)       next_slot_q  <= rd_slot_q;
      if (cmd_i.next_from_first) next_slot_q <= first_slot_q;
      if (cmd_i.prev_from_next) prev_slot_q  <= next_slot_q;
      if (cmd_i.tp_both) begin
        next_tp_q <= now_unix_q + tp_offset(next_hm_q, now_hm_q, 1'b1);
        prev_tp_q <= now_unix_q + tp_offset(prev_hm_q, now_hm_q, 1'b0);
      end
      if (cmd_i.adv) begin
        prev_slot_q <= next_slot_q;
        prev_tp_q   <= next_tp_q;
      end
      if (cmd_i.tp_next) next_tp_q <= now_unix_q + tp_offset(next_hm_q, now_hm_q, 1'b1);
      if (cmd_i.ch_clr)  ch_q <= '0;
      if (cmd_i.ch_inc)  ch_q <= ch_q + 1'b1;
      if (cmd_i.sum)      cnt_q <= 4'(trli_pkg::QUO_W - 1);
      if (cmd_i.div_step) cnt_q <= cnt_q - 1'b1;
      if (cmd_i.out_load)    out_valid_q <= 1'b1;
      else if (out_ready_i)  out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture_now) begin
      now_unix_q       <= now_unix_i;
      now_hm_q.hour    <= now_hour_i;
      now_hm_q.minute  <= now_minute_i;
    end
    if (cmd_i.set_prev)        prev_hm_q  <= rd_ent.hm;
    if (cmd_i.set_first)       first_hm_q <= rd_ent.hm;
    if (cmd_i.set_next)        next_hm_q  <= rd_ent.hm;
    if (cmd_i.next_from_first) next_hm_q  <= first_hm_q;
    if (cmd_i.prev_from_next)  prev_hm_q  <= next_hm_q;
    if (cmd_i.adv)             prev_hm_q  <= next_hm_q;
    if (cmd_i.load_plev)       plev_q     <= rd_ent.lvl;
    if (cmd_i.load_nlev)       nlev_q     <= rd_ent.lvl;
    if (cmd_i.calc_nd) begin
      den_q <= nd_den;
      num_q <= (nd_num > nd_den) ? nd_den : nd_num;
    end
    if (cmd_i.mul) begin
      m1_q <= 40'(plev_q[ch_q]) * 40'(den_q - num_q);
      m2_q <= 40'(nlev_q[ch_q]) * 40'(num_q);
    end
    // rounded quotient: (2x + den) / (2 den), one bit per step
    if (cmd_i.sum) begin
      rem_q <= {41'(m1_q) + 41'(m2_q), 1'b0} + 42'(den_q);
      dsh_q <= 42'({den_q, 1'b0}) << (trli_pkg::QUO_W - 1);
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (rem_q >= dsh_q) begin
        rem_q <= rem_q - dsh_q;
        quo_q <= {quo_q[trli_pkg::QUO_W-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[trli_pkg::QUO_W-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
    if (cmd_i.store) begin
      priority if (den_q == '0)
        res_q[ch_q] <= plev_q[ch_q];
      else if (quo_q > trli_pkg::QUO_W'(trli_pkg::LVL_MAX))
        res_q[ch_q] <= LW'(trli_pkg::LVL_MAX);
      else
        res_q[ch_q] <= quo_q[LW-1:0];
    end
    if (cmd_i.out_load) begin
      out_active_q <= !no_entries_q;
      out_lvl_q    <= no_entries_q ? '0 : res_q;
    end
  end

  always_comb begin
    status_o.rescan_pending = pending_q;
    status_o.no_entries     = no_entries_q;
    status_o.rd_valid       = rd_valid_q;
    status_o.rd_later       = (rd_ent.hm.hour != now_hm_q.hour) ?
                              (rd_ent.hm.hour > now_hm_q.hour) :
                              (rd_ent.hm.minute > now_hm_q.minute);
    status_o.rd_same_next   = (rd_ent.hm == next_hm_q);
    status_o.rd_last        = (rd_slot_q == IW'(SLOTS - 1));
    status_o.adv_needed     = (next_tp_q < now_unix_q);
    status_o.div_done       = (cnt_q == '0);
    status_o.ch_last        = (ch_q == 2'(NC - 1));
    status_o.out_free       = !out_valid_q || out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign active_o      = out_active_q;
  assign level_red_o   = out_lvl_q[0];
  assign level_green_o = out_lvl_q[1];
  assign level_blue_o  = out_lvl_q[2];
  assign level_white_o = out_lvl_q[3];

endmodule

// ----- hw/rtl/timed_rgbw_light_interpolator_top.sv -----
// ----------------------------------------------------------------------------
// timed_rgbw_light_interpolator_top
// day schedule of rgbw levels, interpolated linearly on each time tick
// ----------------------------------------------------------------------------
// A load beat (op 0) writes one schedule slot and marks the schedule for
// rescan; it gives no result. A tick beat (op 1) gives exactly one result
// beat. A tick that follows a load first rescans: a forward pass over the
// slots and, when no valid slot precedes the next one, a cyclic predecessor
// walk. When the next timepoint has passed, an advance walk follows. Every
// tick with a non-empty schedule then reads both level sets and blends the
// four channels one after another (multiply, sum, 9-step restoring divide,
// store). The schedule memory has a single read port and the divider is
// bit-serial. The next beat is taken as soon as the sequencer is back in
// idle, while the finished result waits in the output register.
// ----------------------------------------------------------------------------
module timed_rgbw_light_interpolator_top #(
  parameter int unsigned SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [3:0]  entry_index_i,
  input  logic        entry_valid_i,
  input  logic [4:0]  entry_hour_i,
  input  logic [5:0]  entry_minute_i,
  input  logic [7:0]  entry_red_i,
  input  logic [7:0]  entry_green_i,
  input  logic [7:0]  entry_blue_i,
  input  logic [7:0]  entry_white_i,
  input  logic [31:0] now_unix_i,
  input  logic [4:0]  now_hour_i,
  input  logic [5:0]  now_minute_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        active_o,
  output logic [7:0]  level_red_o,
  output logic [7:0]  level_green_o,
  output logic [7:0]  level_blue_o,
  output logic [7:0]  level_white_o
);

  trli_pkg::cmd_t    cmd;
  trli_pkg::status_t status;

  // sequencer
  trli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (op_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // schedule store, time math and blend arithmetic
  trli_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .entry_index_i  (entry_index_i),
    .entry_valid_i  (entry_valid_i),
    .entry_hour_i   (entry_hour_i),
    .entry_minute_i (entry_minute_i),
    .entry_red_i    (entry_red_i),
    .entry_green_i  (entry_green_i),
    .entry_blue_i   (entry_blue_i),
    .entry_white_i  (entry_white_i),
    .now_unix_i     (now_unix_i),
    .now_hour_i     (now_hour_i),
    .now_minute_i   (now_minute_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .active_o       (active_o),
    .level_red_o    (level_red_o),
    .level_green_o  (level_green_o),
    .level_blue_o   (level_blue_o),
    .level_white_o  (level_white_o)
  );

endmodule

// ----- test/tb_timed_rgbw_light_interpolator_top.sv -----
// ----------------------------------------------------------------------------
// tb_timed_rgbw_light_interpolator_top
// drives schedule loads and clock ticks through the valid/ready input channel,
// predicts the blended rgbw levels per tick and checks every result beat
// ----------------------------------------------------------------------------
module tb_timed_rgbw_light_interpolator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  // one input beat
  typedef struct {
    logic        op;
    logic [3:0]  idx;
    logic        ev;
    logic [4:0]  eh;
    logic [5:0]  em;
    logic [7:0]  lvl [4];
    logic [31:0] unix;
    logic [4:0]  nh;
    logic [5:0]  nm;
  } beat_t;

  // one result beat
  typedef struct {
    logic       active;
    logic [7:0] lvl [4];
  } levels_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        op_i = trli_pkg::OP_LOAD;
  logic [3:0]  entry_index_i = '0;
  logic        entry_valid_i = 1'b0;
  logic [4:0]  entry_hour_i = '0;
  logic [5:0]  entry_minute_i = '0;
  logic [7:0]  entry_red_i = '0;
  logic [7:0]  entry_green_i = '0;
  logic [7:0]  entry_blue_i = '0;
  logic [7:0]  entry_white_i = '0;
  logic [31:0] now_unix_i = '0;
  logic [4:0]  now_hour_i = '0;
  logic [5:0]  now_minute_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        active_o;
  logic [7:0]  level_red_o, level_green_o, level_blue_o, level_white_o;

  timed_rgbw_light_interpolator_top #(.SLOTS(SLOTS)) DUT (.*);

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor state: private copy of the schedule and the interpolation window
  // ---------------------------------------------------------------------------
  logic        sch_valid [SLOTS];
  logic [4:0]  sch_hour  [SLOTS];
  logic [5:0]  sch_min   [SLOTS];
  logic [7:0]  sch_lvl   [SLOTS][4];
  int unsigned win_prev, win_next;
  logic [31:0] prev_tp, next_tp;
  bit          need_rescan, schedule_empty;

  beat_t   pending_beats [$];
  levels_t expected_levels [$];

  int mismatches = 0;
  bit sender_idle_mode = 0, receiver_stall_mode = 0;
  bit hold_receiver = 0;
  bit stimulus_done = 0;
  int idle_pct_in = 0, idle_pct_out = 0;

  function automatic void reset_schedule();
    for (int s = 0; s < SLOTS; s++) begin
      sch_valid[s] = 0;
      sch_hour[s] = '0;
      sch_min[s] = '0;
      for (int c = 0; c < 4; c++) sch_lvl[s][c] = '0;
    end
    sch_valid[0] = 1;
    sch_valid[1] = 1;
    sch_hour[1] = 5'(trli_pkg::NOON_HOUR);
    for (int c = 0; c < 4; c++) sch_lvl[1][c] = 8'(trli_pkg::LVL_MAX);
    win_prev = 0;
    win_next = 0;
    prev_tp = '0;
    next_tp = '0;
    need_rescan = 1;
    schedule_empty = 0;
  endfunction

  // timepoint of slot s; forward picks the next occurrence, else the last one
  function automatic logic [31:0] slot_timepoint(int unsigned s, logic [31:0] unix,
                                                 int nh, int nm, bit forward);
    int dh, dm;
    dh = int'(sch_hour[s]) - nh;
    dm = int'(sch_min[s]) - nm;
    if (forward && (dh < 0 || (dh == 0 && dm < 0))) dh += trli_pkg::HOURS_DAY;
    if (!forward && (dh > 0 || (dh == 0 && dm > 0))) dh -= trli_pkg::HOURS_DAY;
    return unix + 32'((dh * trli_pkg::MIN_PER_H + dm) * trli_pkg::SEC_PER_M);
  endfunction

  function automatic void find_window(logic [31:0] unix, int unsigned nh, int unsigned nm);
    bit got_next, got_prev;
    int unsigned j;
    got_next = 0;
    got_prev = 0;
    for (int s = 0; s < SLOTS; s++) begin
      if (!sch_valid[s]) continue;
      if (sch_hour[s] != nh ? sch_hour[s] > nh : sch_min[s] > nm) begin
        got_next = 1;
        win_next = s;
        break;
      end
      got_prev = 1;
      win_prev = s;
    end
    // nothing later today: wrap to the first valid slot, prev is the last one
    if (!got_next) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (!sch_valid[s]) continue;
        if (!got_next) begin
          got_next = 1;
          win_next = s;
        end
        got_prev = 1;
        win_prev = s;
      end
    end
    schedule_empty = !got_next;
    if (schedule_empty) return;
    // next is the first valid slot: walk cyclically for the predecessor
    if (!got_prev) begin
      j = win_next;
      for (int k = 0; k < SLOTS; k++) begin
        j = (j + 1) % SLOTS;
        if (!sch_valid[j]) continue;
        if (sch_hour[j] == sch_hour[win_next] && sch_min[j] == sch_min[win_next]) break;
        got_prev = 1;
        win_prev = j;
      end
    end
    if (!got_prev) win_prev = win_next;
    next_tp = slot_timepoint(win_next, unix, nh, nm, 1);
    prev_tp = slot_timepoint(win_prev, unix, nh, nm, 0);
  endfunction

  function automatic logic [7:0] mix(logic [7:0] p, logic [7:0] n,
                                     logic [31:0] num, logic [31:0] den);
    logic [63:0] acc, q;
    if (den == 0) return p;
    if (num > den) num = den;
    acc = 64'(p) * 64'(den - num) + 64'(n) * 64'(num);
    q = (2 * acc + 64'(den)) / (2 * 64'(den));
    return (q > trli_pkg::LVL_MAX) ? 8'(trli_pkg::LVL_MAX) : q[7:0];
  endfunction

  function automatic void predict_levels(beat_t b);
    levels_t r;
    int unsigned j;
    if (b.op == trli_pkg::OP_LOAD) begin
      sch_valid[b.idx] = b.ev;
      sch_hour[b.idx] = b.eh;
      sch_min[b.idx] = b.em;
      for (int c = 0; c < 4; c++) sch_lvl[b.idx][c] = b.lvl[c];
      need_rescan = 1;
      return;
    end
    if (need_rescan) begin
      need_rescan = 0;
      find_window(b.unix, b.nh, b.nm);
    end
    r.active = !schedule_empty;
    for (int c = 0; c < 4; c++) r.lvl[c] = '0;
    if (!schedule_empty) begin
      // next passed: slide the window one valid slot forward
      if (next_tp < b.unix) begin
        win_prev = win_next;
        prev_tp = next_tp;
        j = win_next;
        for (int k = 0; k < SLOTS; k++) begin
          j = (j + 1) % SLOTS;
          if (sch_valid[j]) break;
        end
        win_next = j;
        next_tp = slot_timepoint(win_next, b.unix, b.nh, b.nm, 1);
      end
      for (int c = 0; c < 4; c++)
        r.lvl[c] = mix(sch_lvl[win_prev][c], sch_lvl[win_next][c],
                       b.unix - prev_tp, next_tp - prev_tp);
    end
    expected_levels.push_back(r);
  endfunction

  // input beat accepted at the last rising edge
  bit in_taken = 1'b0;
  always @(posedge clk_i) in_taken <= in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // driver: presents queued beats at the falling edge, idles at random
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    beat_t b;
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= idle_pct_in) begin
          b = pending_beats.pop_front();
          predict_levels(b);
          op_i <= b.op;
          entry_index_i <= b.idx;
          entry_valid_i <= b.ev;
          entry_hour_i <= b.eh;
          entry_minute_i <= b.em;
          entry_red_i <= b.lvl[0];
          entry_green_i <= b.lvl[1];
          entry_blue_i <= b.lvl[2];
          entry_white_i <= b.lvl[3];
          now_unix_i <= b.unix;
          now_hour_i <= b.nh;
          now_minute_i <= b.nm;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= !hold_receiver && ($urandom_range(99) >= idle_pct_out);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compares every result beat with the oldest expected levels
  // ---------------------------------------------------------------------------
  int watchdog = 0;
  always @(posedge clk_i) begin
    levels_t e;
    logic [7:0] got [4];
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_timed_rgbw_light_interpolator_top: errors");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        got = '{level_red_o, level_green_o, level_blue_o, level_white_o};
        if (expected_levels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat");
        end else begin
          e = expected_levels.pop_front();
          if (e.active !== active_o || e.lvl[0] !== got[0] || e.lvl[1] !== got[1] ||
              e.lvl[2] !== got[2] || e.lvl[3] !== got[3]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0b %0d %0d %0d %0d got %0b %0d %0d %0d %0d",
                       e.active, e.lvl[0], e.lvl[1], e.lvl[2], e.lvl[3],
                       active_o, got[0], got[1], got[2], got[3]);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  logic [31:0] clock_unix = 32'd1700000000;

  function automatic beat_t make_load(int idx, bit ev, int h, int m,
                                      int r, int g, int bl, int w);
    beat_t b;
    b.op = trli_pkg::OP_LOAD;
    b.idx = 4'(idx);
    b.ev = ev;
    b.eh = 5'(h);
    b.em = 6'(m);
    b.lvl = '{8'(r), 8'(g), 8'(bl), 8'(w)};
    b.unix = $urandom;
    b.nh = 5'($urandom);
    b.nm = 6'($urandom);
    return b;
  endfunction

  function automatic beat_t make_tick(logic [31:0] unix, int h, int m);
    beat_t b;
    b.op = trli_pkg::OP_TICK;
    b.idx = 4'($urandom);
    b.ev = 1'($urandom);
    b.eh = 5'($urandom);
    b.em = 6'($urandom);
    for (int c = 0; c < 4; c++) b.lvl[c] = 8'($urandom);
    b.unix = unix;
    b.nh = 5'(h);
    b.nm = 6'(m);
    return b;
  endfunction

  function automatic beat_t random_load();
    bit wild;
    wild = ($urandom_range(9) == 0);
    return make_load($urandom_range(15), $urandom_range(3) != 0,
                     wild ? $urandom_range(31) : $urandom_range(23),
                     wild ? $urandom_range(63) : $urandom_range(59),
                     $urandom_range(255), $urandom_range(255),
                     $urandom_range(255), $urandom_range(255));
  endfunction

  // ticks mostly walk forward through the day so the window advances
  function automatic beat_t random_tick();
    int mins;
    case ($urandom_range(9))
      0: return make_tick($urandom, $urandom_range(31), $urandom_range(63));
      1: clock_unix = clock_unix + $urandom_range(86400);
      default: clock_unix = clock_unix + 60 * $urandom_range(90);
    endcase
    mins = (clock_unix / 60) % (trli_pkg::HOURS_DAY * trli_pkg::MIN_PER_H);
    return make_tick(clock_unix, mins / trli_pkg::MIN_PER_H, mins % trli_pkg::MIN_PER_H);
  endfunction

  task automatic drain();
    while (pending_beats.size() != 0 || expected_levels.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (8 * SLOTS + 80) @(posedge clk_i);
  endtask

  initial begin
    reset_schedule();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: default schedule, extremes, empty schedule, equal times, wrap
    pending_beats.push_back(make_tick(32'd0, 0, 0));
    pending_beats.push_back(make_tick(32'd21600, 6, 0));
    pending_beats.push_back(make_tick(32'hFFFF_FFFF, 23, 59));
    pending_beats.push_back(make_tick(32'd50000, 31, 63));
    for (int s = 0; s < SLOTS; s++) pending_beats.push_back(make_load(s, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_tick(32'd1234, 10, 20));
    pending_beats.push_back(make_load(15, 1, 23, 59, 255, 0, 255, 0));
    pending_beats.push_back(make_tick(32'd86000, 23, 50));
    pending_beats.push_back(make_load(3, 1, 23, 59, 0, 255, 0, 255));
    pending_beats.push_back(make_tick(32'd86000, 23, 50));
    pending_beats.push_back(make_load(7, 1, 31, 63, 128, 1, 254, 77));
    pending_beats.push_back(make_tick(32'd100, 0, 1));
    pending_beats.push_back(make_tick(32'd90000, 1, 0));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      idle_pct_in = (ph == 1) ? 61 : ((ph == 3) ? 28 : 0);
      idle_pct_out = (ph == 2) ? 61 : ((ph == 3) ? 28 : 0);
      if (ph == 4) hold_receiver = 1;
      for (int n = 0; n < 150; n++) begin
        if ($urandom_range(2) == 0) pending_beats.push_back(random_load());
        else pending_beats.push_back(random_tick());
      end
      if (ph == 4) begin
        // receiver held off while beats stay queued, then released
        repeat (600) @(posedge clk_i);
        hold_receiver = 0;
      end
      drain();
    end

    if (mismatches == 0 && expected_levels.size() == 0) begin
      $display("tb_timed_rgbw_light_interpolator_top: clean");
    end else begin
      $display("tb_timed_rgbw_light_interpolator_top: errors");
    end
    $finish;
  end

endmodule
